[hw/rtl/flowlet_path_selector_top_macros.svh]
// Assertion macros for the flowlet path selector checker.
`ifndef FLOWLET_PATH_SELECTOR_TOP_MACROS_SVH
`define FLOWLET_PATH_SELECTOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define FPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("flowlet path selector check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define FPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flowlet path selector check failed");

`endif

[hw/rtl/fps_pkg.sv]
// Types, codes and helper functions of the flowlet path selector.
package fps_pkg;

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 48;
    localparam int ROUTE_W = 32;
    localparam int GAP_W   = 32;

    // Configuration register indexes
    localparam logic CFG_IS_EDGE     = 1'b0;
    localparam logic CFG_FLOWLET_GAP = 1'b1;

    localparam logic [GAP_W-1:0] FLOWLET_GAP_RESET = 32'd100000;

    // Verdict codes on o_verdict
    localparam logic [1:0] VERDICT_ROUTED   = 2'd0;
    localparam logic [1:0] VERDICT_RECEIVER = 2'd1;
    localparam logic [1:0] VERDICT_HOP_ERR  = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  last_seen;
        logic [ROUTE_W-1:0] route;
    } t_entry;

    function automatic logic [KEY_W-1:0] flow_key(
        input logic [31:0] dest_ip,
        input logic [15:0] src_port,
        input logic [15:0] dst_port,
        input logic [15:0] prio_group
    );
        return {dest_ip, src_port, prio_group | dst_port};
    endfunction

    function automatic logic [31:0] fold_key(input logic [KEY_W-1:0] key);
        return key[31:0] ^ key[63:32];
    endfunction

    function automatic logic [7:0] path_byte(
        input logic [ROUTE_W-1:0] route,
        input logic [1:0]         hop
    );
        return 8'(route >> {hop, 3'b000});
    endfunction

endpackage

[hw/rtl/flowlet_path_selector_top.sv]
// An untagged item at an edge switch goes through the modulo index unit (multiply,
// subtract, fix) and the registered table read; all other items go straight to the result.
// No new item is taken until the current result is written to the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears control and loads the config defaults, then a
// clearing pass writes every table entry invalid before the first item.
module flowlet_path_selector_top
    import fps_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_HOPS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_dest_ip,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [15:0] i_prio_group,
    input  logic [47:0] i_arrival_time,
    input  logic        i_tag_present,
    input  logic [31:0] i_tag_route,
    input  logic [1:0]  i_tag_hops,
    input  logic [31:0] i_fresh_path,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_port,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_new_route,
    output logic [1:0]  o_new_hops,
    output logic        o_path_changed,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [2:0]       HOP_LIM  = 3'(MAX_HOPS);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_INDEX, S_RESULT} t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_clr_idx;
    logic [IDX_W-1:0]    r_idx;
    logic                r_table_item;
    logic [31:0]         r_timeout_count;

    logic                r_is_edge;
    logic [GAP_W-1:0]    r_flowlet_gap;

    logic [KEY_W-1:0]    r_key;
    logic [TIME_W-1:0]   r_arrival_time;
    logic [ROUTE_W-1:0]  r_tag_route;
    logic [1:0]          r_tag_hops;
    logic [ROUTE_W-1:0]  r_fresh_path;

    logic                r_out_valid;
    logic [7:0]          r_out_port;
    logic [1:0]          r_verdict;
    logic [ROUTE_W-1:0]  r_new_route;
    logic [1:0]          r_new_hops;
    logic                r_path_changed;

    logic [KEY_W-1:0]    in_key;
    logic                accept;
    logic                table_sel;
    logic                out_free;
    logic                idx_done;
    logic [IDX_W-1:0]    idx;

    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_waddr;
    t_entry              tbl_wdata;
    t_entry              rd;
    t_entry              upd;

    logic [TIME_W-1:0]   gap;
    logic                key_hit;
    logic                in_gap;
    logic [2:0]          next_hop;

    logic [7:0]          res_port;
    logic [1:0]          res_verdict;
    logic [ROUTE_W-1:0]  res_route;
    logic [1:0]          res_hops;
    logic                res_changed;
    logic                res_timeout;

    assign in_key    = flow_key(i_dest_ip, i_src_port, i_dst_port, i_prio_group);
    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && !o_stall;
    assign table_sel = r_is_edge && !i_tag_present;
    assign out_free  = !r_out_valid || !i_stall;

    fps_index #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_fps_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept && table_sel),
        .i_folded (fold_key(in_key)),
        .o_done   (idx_done),
        .o_index  (idx)
    );

    fps_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_fps_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    ((r_state == S_INDEX) && idx_done),
        .i_raddr (idx),
        .o_rdata (rd)
    );

    // Lookup and routing decision for the held item
    always_comb begin
        gap         = r_arrival_time - rd.last_seen;
        key_hit     = rd.valid && (rd.key == r_key);
        in_gap      = (gap <= {16'd0, r_flowlet_gap});
        next_hop    = {1'b0, r_tag_hops} + 3'd1;
        res_port    = '0;
        res_verdict = VERDICT_ROUTED;
        res_route   = '0;
        res_hops    = '0;
        res_changed = 1'b0;
        res_timeout = 1'b0;
        upd.valid     = 1'b1;
        upd.key       = r_key;
        upd.last_seen = r_arrival_time;
        upd.route     = r_fresh_path;
        if (r_table_item) begin
            if (key_hit && in_gap) begin
                upd.route = rd.route;
            end else begin
                res_changed = 1'b1;
                res_timeout = key_hit;
            end
            res_port  = path_byte(upd.route, 2'd0);
            res_route = upd.route;
        end else if (r_is_edge) begin
            // receiver side: strip the tag
            res_verdict = VERDICT_RECEIVER;
        end else if (next_hop >= HOP_LIM) begin
            res_verdict = VERDICT_HOP_ERR;
            res_route   = r_tag_route;
        end else begin
            res_port  = path_byte(r_tag_route, next_hop[1:0]);
            res_route = r_tag_route;
            res_hops  = next_hop[1:0];
        end
    end

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_idx;
        tbl_wdata = upd;
        if (r_state == S_CLEAR) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr_idx;
            tbl_wdata = '0;
        end else if (r_state == S_RESULT && r_table_item && out_free) begin
            tbl_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_edge     <= 1'b0;
            r_flowlet_gap <= FLOWLET_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IS_EDGE:     r_is_edge     <= i_cfg_data[0];
                CFG_FLOWLET_GAP: r_flowlet_gap <= i_cfg_data;
                default:         r_is_edge     <= r_is_edge;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_idx       <= '0;
            r_out_valid     <= 1'b0;
            r_timeout_count <= '0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_key          <= in_key;
                        r_arrival_time <= i_arrival_time;
                        r_tag_route    <= i_tag_route;
                        r_tag_hops     <= i_tag_hops;
                        r_fresh_path   <= i_fresh_path;
                        r_table_item   <= table_sel;
                        r_state        <= table_sel ? S_INDEX : S_RESULT;
                    end
                end
                S_INDEX: begin
                    if (idx_done) begin
                        r_idx   <= idx;
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_port     <= res_port;
                        r_verdict      <= res_verdict;
                        r_new_route    <= res_route;
                        r_new_hops     <= res_hops;
                        r_path_changed <= res_changed;
                        if (res_timeout) begin
                            r_timeout_count <= r_timeout_count + 32'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_port     = r_out_port;
    assign o_verdict      = r_verdict;
    assign o_new_route    = r_new_route;
    assign o_new_hops     = r_new_hops;
    assign o_path_changed = r_path_changed;

endmodule

[hw/rtl/fps_index.sv]
// Table index unit: folded key modulo the table depth by reciprocal multiply.
module fps_index
    import fps_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [31:0]                    i_folded,
    output logic                           o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_index
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int REM_W = IDX_W + 1;
    localparam logic [31:0]      RECIP   = 32'((64'd1 << 32) / TABLE_DEPTH);
    localparam logic [31:0]      DEPTH_W = 32'(TABLE_DEPTH);
    localparam logic [REM_W-1:0] DEPTH_R = REM_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {IX_IDLE, IX_MUL, IX_SUB, IX_FIX} t_ix_state;

    t_ix_state        r_state;
    logic [31:0]      r_x;
    logic [31:0]      r_q;
    logic [REM_W-1:0] r_rem;
    logic [63:0]      prod;

    assign prod = 64'(r_x) * 64'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IX_IDLE;
        end else begin
            unique case (r_state)
                IX_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_folded;
                        r_state <= IX_MUL;
                    end
                end
                IX_MUL: begin
                    // quotient estimate, low by at most one
                    r_q     <= prod[63:32];
                    r_state <= IX_SUB;
                end
                IX_SUB: begin
                    r_rem   <= REM_W'(r_x - 32'(r_q * DEPTH_W));
                    r_state <= IX_FIX;
                end
                IX_FIX: begin
                    r_state <= IX_IDLE;
                end
                default: r_state <= IX_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == IX_FIX);
    assign o_index = (r_rem >= DEPTH_R) ? IDX_W'(r_rem - DEPTH_R) : IDX_W'(r_rem);

endmodule

[hw/rtl/fps_table.sv]
// Flowlet table memory: one write port, one read port, registered read data.
module fps_table
    import fps_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_waddr,
    input  t_entry                         i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_raddr,
    output t_entry                         o_rdata
);

    t_entry mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fps_checker.sv]
// Port-level checks of the flowlet path selector, bound to the top level.
`include "flowlet_path_selector_top_macros.svh"

module fps_checker
    import fps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_port,
    input logic [1:0]  o_verdict,
    input logic [31:0] o_new_route,
    input logic [1:0]  o_new_hops,
    input logic        o_path_changed
);

    logic        no_route;
    logic        out_rx;
    logic        out_err;
    logic        out_routed;
    logic [44:0] out_payload;

    assign no_route    = (o_out_port == 8'd0) && (o_new_hops == 2'd0) && !o_path_changed;
    assign out_rx      = o_valid && (o_verdict == VERDICT_RECEIVER);
    assign out_err     = o_valid && (o_verdict == VERDICT_HOP_ERR);
    assign out_routed  = o_valid && (o_verdict == VERDICT_ROUTED);
    assign out_payload = {o_out_port, o_verdict, o_new_route, o_new_hops, o_path_changed};

    // receiver items carry nothing but the verdict
    `FPS_ASSERT_NOW(a_receiver_empty, out_rx, no_route && (o_new_route == 32'd0))

    `FPS_ASSERT_NOW(a_hop_err_no_port, out_err, no_route)

    // a new flowlet is only picked on the edge lookup path
    `FPS_ASSERT_NOW(a_change_is_edge, o_valid && o_path_changed, out_routed && (o_new_hops == 2'd0))

    `FPS_ASSERT_NOW(a_port_from_route, out_routed && (o_new_hops == 2'd0), o_out_port == o_new_route[7:0])

    `FPS_ASSERT_NEXT(a_stalled_hold, o_valid && i_stall, o_valid && $stable(out_payload))

endmodule

bind flowlet_path_selector_top fps_checker u_fps_checker (.*);
